// ===== rtl/eartm_pkg.sv =====
// ============================================================================
// eartm_pkg
// Shared constants, types and helpers for the Euler angle to rotation
// matrix block: angle units, CORDIC step table and the cell type.
// ============================================================================
package eartm_pkg;

    localparam int CORDIC_STEPS_DEF  = 16;
    localparam int FRACTION_BITS_DEF = 14;
    localparam int TABLE_LEN         = 24;
    localparam int OUT_FRAC          = 14;
    localparam int UNITS_PER_TURN    = 23040;
    localparam int UNITS_HALF_TURN   = 11520;
    localparam int UNITS_QTR_TURN    = 5760;

    // CORDIC datapath width: Q30 with headroom for the gain growth
    localparam int CW = 34;
    // binary angle width: 2^32 per turn, residual stays well below 2^31
    localparam int AW = 34;

    localparam logic signed [CW-1:0] GAIN_Q30 = CW'(652032874);

    typedef logic signed [CW-1:0] t_cval;
    typedef logic signed [AW-1:0] t_ang;

    // data handed from one CORDIC cell to the next
    typedef struct packed {
        t_cval x;
        t_cval y;
        t_ang  z;
        logic  neg;
    } t_cell;

    // step angles atan(2^-i), 2^32 per turn
    function automatic t_ang step_angle(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h20000000;  1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;  3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;  9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;  11: v = 32'h000517CC;
            12: v = 32'h00028BE6;  13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;  15: v = 32'h0000517D;
            16: v = 32'h000028BE;  17: v = 32'h0000145F;
            18: v = 32'h00000A30;  19: v = 32'h00000518;
            20: v = 32'h0000028C;  21: v = 32'h00000146;
            22: v = 32'h000000A3;  23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return t_ang'({2'b00, v});
    endfunction

endpackage

// ===== rtl/euler_angles_to_rotation_matrix_top.sv =====
// Throughput: one transaction per cycle; the pipeline advances whenever the
// output register is free or being taken.
// Reset: i_rst_n synchronous, active low, clears the valid pipeline only.
// ============================================================================
// euler_angles_to_rotation_matrix_top
// Three Euler angles to the 3x3 rotation matrix Rx*Ry*Rz in Q1.14.
// ============================================================================
module euler_angles_to_rotation_matrix_top
    import eartm_pkg::*;
#(
    parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_angle_x,
    input  logic signed [15:0] i_angle_y,
    input  logic signed [15:0] i_angle_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_m00,
    output logic signed [15:0] o_m01,
    output logic signed [15:0] o_m02,
    output logic signed [15:0] o_m10,
    output logic signed [15:0] o_m11,
    output logic signed [15:0] o_m12,
    output logic signed [15:0] o_m20,
    output logic signed [15:0] o_m21,
    output logic signed [15:0] o_m22
);

    localparam int NS  = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int LAT = NS + 7;
    localparam int FB  = FRACTION_BITS;
    localparam int SW  = FB + 2;
    localparam int PW  = 2 * SW + 2;

    // whole pipeline moves together; stall only when the output is held
    logic en;
    logic [LAT-1:0] r_vld;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    logic signed [SW-1:0] sx, cx, sy, cy, sz, cz;

    eartm_sincos #(.CORDIC_STEPS(CORDIC_STEPS), .FRACTION_BITS(FB)) u_sc_x (
        .i_clk(i_clk), .i_en(en), .i_angle(i_angle_x), .o_sin(sx), .o_cos(cx));
    eartm_sincos #(.CORDIC_STEPS(CORDIC_STEPS), .FRACTION_BITS(FB)) u_sc_y (
        .i_clk(i_clk), .i_en(en), .i_angle(i_angle_y), .o_sin(sy), .o_cos(cy));
    eartm_sincos #(.CORDIC_STEPS(CORDIC_STEPS), .FRACTION_BITS(FB)) u_sc_z (
        .i_clk(i_clk), .i_en(en), .i_angle(i_angle_z), .o_sin(sz), .o_cos(cz));

    function automatic logic signed [PW-1:0] rsh(input logic signed [PW-1:0] v);
        return (v + (PW'(1) <<< (FB - 1))) >>> FB;
    endfunction

    // stage A: products for P = Ry*Rz
    logic signed [PW-1:0] r_pa, r_pb, r_pc, r_pd;
    logic signed [SW-1:0] r_sx, r_cx, r_sy, r_cy, r_sz, r_cz;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pa <= PW'(cy) * PW'(cz);
            r_pb <= PW'(cy) * PW'(sz);
            r_pc <= PW'(sy) * PW'(cz);
            r_pd <= PW'(sy) * PW'(sz);
            r_sx <= sx; r_cx <= cx; r_sy <= sy;
            r_cy <= cy; r_sz <= sz; r_cz <= cz;
        end
    end

    // stage B: round P
    logic signed [SW:0] r_p00, r_p01, r_p02, r_p10, r_p11, r_p20, r_p21, r_p22;
    logic signed [SW-1:0] r_sx2, r_cx2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p00 <= (SW+1)'(rsh(r_pa));
            r_p01 <= (SW+1)'(rsh(r_pb));
            r_p02 <= -(SW+1)'(r_sy);
            r_p10 <= -(SW+1)'(r_sz);
            r_p11 <= (SW+1)'(r_cz);
            r_p20 <= (SW+1)'(rsh(r_pc));
            r_p21 <= (SW+1)'(rsh(r_pd));
            r_p22 <= (SW+1)'(r_cy);
            r_sx2 <= r_sx; r_cx2 <= r_cx;
        end
    end

    // stage C: products of Rx with P rows 1 and 2
    logic signed [PW-1:0] r_c1 [3], r_s2 [3], r_c2 [3], r_s1 [3];
    logic signed [SW:0]   r_row0 [3];
    logic signed [SW:0]   p1 [3], p2 [3];
    always_comb begin
        p1[0] = r_p10; p1[1] = r_p11; p1[2] = '0;
        p2[0] = r_p20; p2[1] = r_p21; p2[2] = r_p22;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                r_c1[j] <= PW'(r_cx2) * PW'(p1[j]);
                r_s2[j] <= PW'(r_sx2) * PW'(p2[j]);
                r_c2[j] <= PW'(r_cx2) * PW'(p2[j]);
                r_s1[j] <= PW'(r_sx2) * PW'(p1[j]);
            end
            r_row0[0] <= r_p00; r_row0[1] <= r_p01; r_row0[2] <= r_p02;
        end
    end

    // stage D: sums, round, rescale to Q14 and saturate
    function automatic logic signed [15:0] to_out(input logic signed [PW-1:0] v);
        logic signed [PW+16:0] t;
        t = (PW+17)'(v);
        if (FB > OUT_FRAC) t = (t + ((PW+17)'(1) <<< (FB - OUT_FRAC - 1))) >>> (FB - OUT_FRAC);
        else               t = t <<< (OUT_FRAC - FB);
        if (t > (PW+17)'(16384))  t = (PW+17)'(16384);
        if (t < -(PW+17)'(16384)) t = -(PW+17)'(16384);
        return 16'(t);
    endfunction

    logic signed [15:0] m [9];
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            m[j]   = to_out(PW'(r_row0[j]));
            m[3+j] = to_out(rsh(r_c1[j] + r_s2[j]));
            m[6+j] = to_out(rsh(r_c2[j] - r_s1[j]));
        end
    end

    logic signed [15:0] r_m [9];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 9; k++) r_m[k] <= m[k];
        end
    end

    assign o_m00 = r_m[0]; assign o_m01 = r_m[1]; assign o_m02 = r_m[2];
    assign o_m10 = r_m[3]; assign o_m11 = r_m[4]; assign o_m12 = r_m[5];
    assign o_m20 = r_m[6]; assign o_m21 = r_m[7]; assign o_m22 = r_m[8];

endmodule

// ===== rtl/eartm_reduce.sv =====
// ============================================================================
// eartm_reduce
// Angle reduction: wraps an angle into one turn, folds it into +-90 degrees
// and converts it to a binary angle. Two register stages.
// ============================================================================
module eartm_reduce
    import eartm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [15:0] i_angle,
    output t_cell              o_cell
);

    // stage 1: wrap and fold
    logic signed [15:0] n_r;
    logic signed [15:0] r_r;
    logic               n_neg, r_neg;
    logic signed [17:0] w;

    always_comb begin
        w = 18'(i_angle);
        // i_angle in [-32768,32767]: at most two turns either way
        if (w < -18'sd34560)      w = w + 18'sd46080;
        else if (w < -18'sd11520) w = w + 18'sd23040;
        else if (w >= 18'sd34560) w = w - 18'sd46080;
        else if (w >= 18'sd11520) w = w - 18'sd23040;
        n_neg = 1'b0;
        if (w > 18'sd5760) begin
            w     = w - 18'sd11520;
            n_neg = 1'b1;
        end else if (w < -18'sd5760) begin
            w     = w + 18'sd11520;
            n_neg = 1'b1;
        end
        n_r = 16'(w);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r   <= n_r;
            r_neg <= n_neg;
        end
    end

    // stage 2: q = floor((mag * 2^32 + 11520) / 23040) = floor((mag * 2^24 + 45) / 90)
    // 2^24 = 90 * 186413 + 46, so q = mag * 186413 + floor((46 * mag + 45) / 90);
    // the small quotient is exact by reciprocal since 46 * mag + 45 < 2^19
    localparam logic [17:0] K_WHOLE = 18'd186413;   // floor(2^23 / 45)
    localparam logic [25:0] K_RECIP = 26'd47721859; // ceil(2^32 / 90)
    logic [12:0] mag;
    logic [30:0] q_hi;
    logic [18:0] num;
    logic [44:0] prod;
    t_ang        z;
    t_cell       n_cell;

    always_comb begin
        mag  = r_r[15] ? 13'(-r_r) : 13'(r_r);
        q_hi = 31'(mag) * 31'(K_WHOLE);
        num  = 19'(mag) * 19'd46 + 19'd45;
        prod = 45'(num) * 45'(K_RECIP);
        z    = t_ang'(q_hi) + t_ang'(prod[44:32]);
        if (r_r[15]) z = -z;
        n_cell.x   = GAIN_Q30;
        n_cell.y   = '0;
        n_cell.z   = z;
        n_cell.neg = r_neg;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) o_cell <= n_cell;
    end

endmodule

// ===== rtl/eartm_cordic_cell.sv =====
// ============================================================================
// eartm_cordic_cell
// One CORDIC micro-rotation with a fixed shift, registered.
// ============================================================================
module eartm_cordic_cell
    import eartm_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_cell i_cell,
    output t_cell o_cell
);

    t_cell n_cell;
    t_cval dx, dy;

    always_comb begin
        dx     = i_cell.y >>> STEP;
        dy     = i_cell.x >>> STEP;
        n_cell = i_cell;
        if (!i_cell.z[AW-1]) begin
            n_cell.x = i_cell.x - dx;
            n_cell.y = i_cell.y + dy;
            n_cell.z = i_cell.z - step_angle(STEP);
        end else begin
            n_cell.x = i_cell.x + dx;
            n_cell.y = i_cell.y - dy;
            n_cell.z = i_cell.z + step_angle(STEP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) o_cell <= n_cell;
    end

endmodule

// ===== rtl/eartm_sincos.sv =====
// ============================================================================
// eartm_sincos
// Sine and cosine of one angle: reduction followed by a chain of CORDIC
// cells and a rounding stage.
// ============================================================================
module eartm_sincos
    import eartm_pkg::*;
#(
    parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [15:0]            i_angle,
    output logic signed [FRACTION_BITS+1:0] o_sin,
    output logic signed [FRACTION_BITS+1:0] o_cos
);

    localparam int NS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int SH = 30 - FRACTION_BITS;
    localparam logic signed [CW-1:0] ONE = CW'(1) <<< FRACTION_BITS;

    t_cell chain [NS+1];

    eartm_reduce u_reduce (
        .i_clk   (i_clk),
        .i_en    (i_en),
        .i_angle (i_angle),
        .o_cell  (chain[0])
    );

    // row of CORDIC cells
    for (genvar g = 0; g < NS; g++) begin : g_cell
        eartm_cordic_cell #(.STEP(g)) u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_cell (chain[g]),
            .o_cell (chain[g+1])
        );
    end

    // round, clamp and apply the fold sign
    function automatic t_cval rnd_clamp(input t_cval v);
        t_cval t;
        if (SH > 0) t = (v + (CW'(1) <<< (SH - 1))) >>> SH;
        else        t = v;
        if (t > ONE)  t = ONE;
        if (t < -ONE) t = -ONE;
        return t;
    endfunction

    t_cval cv, sv;

    always_comb begin
        cv = rnd_clamp(chain[NS].x);
        sv = rnd_clamp(chain[NS].y);
        if (chain[NS].neg) begin
            cv = -cv;
            sv = -sv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sin <= (FRACTION_BITS+2)'(sv);
            o_cos <= (FRACTION_BITS+2)'(cv);
        end
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb
// Regression for the Euler angle to rotation matrix block: a bit-exact
// predictor of CORDIC sine/cosine and the fixed-point matrix product is run
// against the DUT under random valid/stall pressure.
// ============================================================================
module tb;
    import eartm_pkg::*;

    localparam int STEPS = CORDIC_STEPS_DEF;
    localparam int FB    = FRACTION_BITS_DEF;
    localparam int LAT   = STEPS + 7;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    } t_matrix;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [15:0] i_angle_x, i_angle_y, i_angle_z;
    logic               o_valid;
    logic               i_stall;
    logic signed [15:0] o_m00, o_m01, o_m02, o_m10, o_m11, o_m12, o_m20, o_m21, o_m22;

    t_matrix matrix_q[$];
    int      n_errors;
    int      n_sent;
    int      n_checked;
    longint  cycle_cnt;
    bit      calm;          // no idling on either side
    int      hold_req;      // long receiver hold-off, in cycles

    euler_angles_to_rotation_matrix_top dut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic longint fshift(longint x, int n);
        if (n == 0) return x;
        return x >>> n;
    endfunction

    function automatic longint rshift(longint x, int n);
        if (n == 0) return x;
        return fshift(x + (longint'(1) << (n - 1)), n);
    endfunction

    function automatic longint clampv(longint x, longint lim);
        if (x > lim) return lim;
        if (x < -lim) return -lim;
        return x;
    endfunction

    function automatic void trig(input logic signed [15:0] ang,
                                 output longint sn, output longint cs);
        longint r, mag, z, x, y, dx, dy;
        bit     neg;
        neg = 0;
        r = longint'(ang) % UNITS_PER_TURN;
        if (r < 0) r += UNITS_PER_TURN;
        if (r >= UNITS_HALF_TURN) r -= UNITS_PER_TURN;
        if (r > UNITS_QTR_TURN) begin
            r -= UNITS_HALF_TURN; neg = 1;
        end else if (r < -UNITS_QTR_TURN) begin
            r += UNITS_HALF_TURN; neg = 1;
        end
        mag = (r < 0) ? -r : r;
        z = ((mag << 32) + UNITS_HALF_TURN) / UNITS_PER_TURN;
        if (r < 0) z = -z;
        x = 652032874;
        y = 0;
        for (int i = 0; i < STEPS && i < TABLE_LEN; i++) begin
            dx = fshift(y, i);
            dy = fshift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(step_angle(i));
            end else begin
                x += dx; y -= dy; z += longint'(step_angle(i));
            end
        end
        cs = clampv(rshift(x, 30 - FB), longint'(1) << FB);
        sn = clampv(rshift(y, 30 - FB), longint'(1) << FB);
        if (neg) begin
            cs = -cs; sn = -sn;
        end
    endfunction

    function automatic logic signed [15:0] to_q14(longint v);
        if (FB > OUT_FRAC) v = rshift(v, FB - OUT_FRAC);
        else v = v * (longint'(1) << (OUT_FRAC - FB));
        return 16'(clampv(v, longint'(1) << OUT_FRAC));
    endfunction

    function automatic t_matrix rotation_of(logic signed [15:0] ax, logic signed [15:0] ay,
                                            logic signed [15:0] az);
        longint sx, cx, sy, cy, sz, cz;
        longint p[3][3];
        longint m[3][3];
        t_matrix r;
        trig(ax, sx, cx);
        trig(ay, sy, cy);
        trig(az, sz, cz);
        p[0][0] = rshift(cy * cz, FB); p[0][1] = rshift(cy * sz, FB); p[0][2] = -sy;
        p[1][0] = -sz;                 p[1][1] = cz;                  p[1][2] = 0;
        p[2][0] = rshift(sy * cz, FB); p[2][1] = rshift(sy * sz, FB); p[2][2] = cy;
        for (int j = 0; j < 3; j++) begin
            m[0][j] = p[0][j];
            m[1][j] = rshift(cx * p[1][j] + sx * p[2][j], FB);
            m[2][j] = rshift(cx * p[2][j] - sx * p[1][j], FB);
        end
        r.m00 = to_q14(m[0][0]); r.m01 = to_q14(m[0][1]); r.m02 = to_q14(m[0][2]);
        r.m10 = to_q14(m[1][0]); r.m11 = to_q14(m[1][1]); r.m12 = to_q14(m[1][2]);
        r.m20 = to_q14(m[2][0]); r.m21 = to_q14(m[2][1]); r.m22 = to_q14(m[2][2]);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // sender: one transaction, with optional random gap first; valid stays
    // high after acceptance so the next transaction can follow directly
    // ------------------------------------------------------------------------
    task automatic send_angles(logic signed [15:0] ax, logic signed [15:0] ay,
                               logic signed [15:0] az);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_angle_x <= ax;
        i_angle_y <= ay;
        i_angle_z <= az;
        matrix_q.push_back(rotation_of(ax, ay, az));
        n_sent++;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (matrix_q.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // receiver: random stall bursts plus long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                i_stall <= 1'b1;
                repeat (hold_req) @(posedge i_clk);
                hold_req = 0;
                i_stall <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_matrix got, exp_m;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_m00, o_m01, o_m02, o_m10, o_m11, o_m12, o_m20, o_m21, o_m22};
            if (matrix_q.size() == 0) begin
                $display("%0t: unexpected transaction, actual %h", $time, got);
                n_errors++;
            end else begin
                exp_m = matrix_q.pop_front();
                n_checked++;
                if (got !== exp_m) begin
                    $display("%0t: mismatch expected %h actual %h", $time, exp_m, got);
                    n_errors++;
                end
            end
        end
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("euler_angles_to_rotation_matrix_top regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    function automatic logic signed [15:0] nominal_angle();
        return 16'($signed($urandom_range(0, 46080)) - 23040);
    endfunction

    task automatic test_directed();
        logic signed [15:0] pts[$] = '{16'sd0, 16'sd5760, -16'sd5760, 16'sd11520,
                                       -16'sd11520, 16'sd23040, -16'sd23040, 16'sd1,
                                       16'sh7FFF, 16'sh8000, 16'sd5761, -16'sd5761};
        foreach (pts[i]) send_angles(pts[i], pts[(i + 3) % pts.size()],
                                     pts[(i + 7) % pts.size()]);
        send_angles(16'sd11520, 16'sd11520, 16'sd11520);  // half turn everywhere
        send_angles(16'shFFFF, 16'shFFFF, 16'shFFFF);
        send_angles(16'sh5555, 16'shAAAA, 16'sh5555);
        send_angles(16'shAAAA, 16'sh5555, 16'shAAAA);
        wait_drained();
    endtask

    task automatic test_backpressure();
        // long receiver hold-off while the sender keeps offering
        hold_req = 3 * LAT + 20;
        repeat (LAT + 20) send_angles(nominal_angle(), nominal_angle(), nominal_angle());
        wait_drained();
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) == 0)
                send_angles(16'($urandom), 16'($urandom), 16'($urandom));
            else
                send_angles(nominal_angle(), nominal_angle(), nominal_angle());
        end
    endtask

    task automatic test_streaming(int n);
        calm = 1;
        test_random(n);
        wait_drained();
    endtask

    initial begin
        n_errors = 0; n_sent = 0; n_checked = 0; cycle_cnt = 0;
        calm = 0; hold_req = 0;
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_angle_x <= '0;
        i_angle_y <= '0;
        i_angle_z <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random(300);
        wait_drained();        // sender pauses until all results are back
        test_random(250);
        test_streaming(150);
        repeat (LAT + 10) @(posedge i_clk);
        $display("Sent %0d angle sets, checked %0d matrices, incl. wrap, half-turn", n_sent,
                 n_checked);
        $display("and back-pressure cases; %0d errors.", n_errors);
        if (n_errors == 0 && matrix_q.size() == 0)
            $display("euler_angles_to_rotation_matrix_top regression: pass");
        else
            $display("euler_angles_to_rotation_matrix_top regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/eartm_pkg.sv
rtl/eartm_reduce.sv
rtl/eartm_cordic_cell.sv
rtl/eartm_sincos.sv
rtl/euler_angles_to_rotation_matrix_top.sv
dv/tb.sv
